/* design/dvdd_pkg.sv */
package dvdd_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 6;
    localparam int unsigned DIST_W   = 22;
    localparam int unsigned DNUM_W   = 23;
    localparam int unsigned Q100_W   = 8;
    localparam int unsigned R100_W   = 7;
    localparam int unsigned LEN_W    = 5;
    localparam int unsigned DOFF_W   = 9;
    localparam int unsigned NUM_STG  = 4;
    localparam int unsigned NUM_DATE = 2;

    localparam int unsigned MIN_YEAR_DEFAULT = 1900;
    localparam int unsigned MAX_YEAR_DEFAULT = 9999;

    // y / 100 == (y * Q100_MUL) >> Q100_SHIFT for every 14-bit y
    localparam int unsigned Q100_MUL   = 5243;
    localparam int unsigned Q100_SHIFT = 19;
    localparam int unsigned PROD_W     = YEAR_W + 13;

    localparam int unsigned DAYS_YEAR    = 365;
    localparam int unsigned YEARS_CENT   = 100;
    localparam int unsigned FEB_LEAP_LEN = 29;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [YEAR_W-1:0]  year_a;
        logic [MONTH_W-1:0] month_a;
        logic [DAY_W-1:0]   day_a;
        logic [YEAR_W-1:0]  year_b;
        logic [MONTH_W-1:0] month_b;
        logic [DAY_W-1:0]   day_b;
    } t_req;

    typedef struct packed {
        logic              valid_a;
        logic              valid_b;
        logic [DIST_W-1:0] distance;
    } t_rsp;

    function automatic logic [DOFF_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOFF_W-1:0] v;
        case (m)
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [LEN_W-1:0] v;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   v = 5'd30;
            4'd2:                                      v = 5'd28;
            default:                                   v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

/* design/dvdd_if.sv */
interface dvdd_req_if;
    logic             valid;
    logic             ready;
    dvdd_pkg::t_req   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dvdd_rsp_if;
    logic             valid;
    logic             ready;
    dvdd_pkg::t_rsp   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/date_validate_and_day_distance_top.sv */
// Gregorian date check and day distance.
// i_req carries two dates (year, month, day each); o_rsp returns one beat per
// request beat: a valid flag per date and the absolute day distance, which
// is 0 unless both dates are valid. Years outside [MIN_YEAR_BOUND,
// MAX_YEAR_BOUND], months outside 1..12 and days outside 1..month length
// (February 29 in leap years) are invalid.
// Throughput: one beat per cycle while o_rsp.ready is high, through the four
// register stages (divide-by-100 multiply, leap and day-count terms,
// day-number sum, absolute difference).
// Each stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up under a stall. When o_rsp.ready
// is low the result holds on o_rsp; i_req.ready drops only once all four
// stages hold beats. Reset (synchronous, i_rst_n low) empties the pipeline;
// no beat is lost or repeated across a stall.
module date_validate_and_day_distance_top #(
    parameter int unsigned MIN_YEAR_BOUND = dvdd_pkg::MIN_YEAR_DEFAULT,
    parameter int unsigned MAX_YEAR_BOUND = dvdd_pkg::MAX_YEAR_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dvdd_req_if.sink           i_req,
    dvdd_rsp_if.source         o_rsp
);

    localparam logic [dvdd_pkg::YEAR_W-1:0] MinYear = dvdd_pkg::YEAR_W'(MIN_YEAR_BOUND);
    localparam logic [dvdd_pkg::YEAR_W-1:0] MaxYear = dvdd_pkg::YEAR_W'(MAX_YEAR_BOUND);

    logic [dvdd_pkg::NUM_STG-1:0] r_v;
    logic [dvdd_pkg::NUM_STG-1:0] en;

    logic [dvdd_pkg::YEAR_W-1:0]  in_year  [dvdd_pkg::NUM_DATE];
    logic [dvdd_pkg::MONTH_W-1:0] in_month [dvdd_pkg::NUM_DATE];
    logic [dvdd_pkg::DAY_W-1:0]   in_day   [dvdd_pkg::NUM_DATE];

    // stage 1
    logic [dvdd_pkg::YEAR_W-1:0]  r1_year  [dvdd_pkg::NUM_DATE];
    logic [dvdd_pkg::MONTH_W-1:0] r1_month [dvdd_pkg::NUM_DATE];
    logic [dvdd_pkg::DAY_W-1:0]   r1_day   [dvdd_pkg::NUM_DATE];
    logic [dvdd_pkg::Q100_W-1:0]  r1_q100  [dvdd_pkg::NUM_DATE];
    logic [dvdd_pkg::LEN_W-1:0]   r1_len   [dvdd_pkg::NUM_DATE];
    logic                         r1_ok    [dvdd_pkg::NUM_DATE];
    logic [dvdd_pkg::Q100_W-1:0]  n1_q100  [dvdd_pkg::NUM_DATE];
    logic                         n1_ok    [dvdd_pkg::NUM_DATE];

    // stage 2
    logic [dvdd_pkg::DNUM_W-1:0]  r2_base  [dvdd_pkg::NUM_DATE];
    logic [dvdd_pkg::DOFF_W-1:0]  r2_off   [dvdd_pkg::NUM_DATE];
    logic                         r2_ok    [dvdd_pkg::NUM_DATE];
    logic [dvdd_pkg::DNUM_W-1:0]  n2_base  [dvdd_pkg::NUM_DATE];
    logic [dvdd_pkg::DOFF_W-1:0]  n2_off   [dvdd_pkg::NUM_DATE];
    logic                         n2_ok    [dvdd_pkg::NUM_DATE];

    // stage 3
    logic [dvdd_pkg::DNUM_W-1:0]  r3_dnum  [dvdd_pkg::NUM_DATE];
    logic                         r3_ok    [dvdd_pkg::NUM_DATE];

    // stage 4
    dvdd_pkg::t_rsp               r4_rsp;
    dvdd_pkg::t_rsp               n4_rsp;

    assign in_year[0]  = i_req.data.year_a;
    assign in_month[0] = i_req.data.month_a;
    assign in_day[0]   = i_req.data.day_a;
    assign in_year[1]  = i_req.data.year_b;
    assign in_month[1] = i_req.data.month_b;
    assign in_day[1]   = i_req.data.day_b;

    always_comb begin
        en[dvdd_pkg::NUM_STG-1] = !r_v[dvdd_pkg::NUM_STG-1] || o_rsp.ready;
        for (int k = dvdd_pkg::NUM_STG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_req.ready = en[0];
    assign o_rsp.valid = r_v[dvdd_pkg::NUM_STG-1];
    assign o_rsp.data  = r4_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_req.valid;
            end
            for (int k = 1; k < dvdd_pkg::NUM_STG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: year / 100 by reciprocal, range checks
    always_comb begin
        logic [dvdd_pkg::PROD_W-1:0] prod;
        for (int k = 0; k < dvdd_pkg::NUM_DATE; k++) begin
            prod = dvdd_pkg::PROD_W'(in_year[k])
                 * dvdd_pkg::PROD_W'(dvdd_pkg::Q100_MUL);
            n1_q100[k] = dvdd_pkg::Q100_W'(prod >> dvdd_pkg::Q100_SHIFT);
            n1_ok[k]   = (in_year[k] >= MinYear) && (in_year[k] <= MaxYear)
                      && (in_month[k] inside {[dvdd_pkg::MONTH_JAN:dvdd_pkg::MONTH_DEC]})
                      && (in_day[k] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < dvdd_pkg::NUM_DATE; k++) begin
                r1_year[k]  <= in_year[k];
                r1_month[k] <= in_month[k];
                r1_day[k]   <= in_day[k];
                r1_q100[k]  <= n1_q100[k];
                r1_len[k]   <= dvdd_pkg::month_len(in_month[k]);
                r1_ok[k]    <= n1_ok[k];
            end
        end
    end

    // stage 2: leap rule, day check, leap count and 365 * year
    always_comb begin
        logic [dvdd_pkg::R100_W-1:0] r100;
        logic                        rem_nz;
        logic                        leap;
        logic [dvdd_pkg::LEN_W-1:0]  len;
        logic [dvdd_pkg::YEAR_W-1:0] c4;
        logic [dvdd_pkg::Q100_W:0]   c100;
        logic [dvdd_pkg::Q100_W-2:0] c400;
        for (int k = 0; k < dvdd_pkg::NUM_DATE; k++) begin
            r100   = dvdd_pkg::R100_W'(r1_year[k]
                   - dvdd_pkg::YEAR_W'(dvdd_pkg::YEAR_W'(r1_q100[k])
                   * dvdd_pkg::YEAR_W'(dvdd_pkg::YEARS_CENT)));
            rem_nz = (r100 != '0);
            leap   = (rem_nz && (r1_year[k][1:0] == 2'b00))
                  || (!rem_nz && (r1_q100[k][1:0] == 2'b00));
            len    = (r1_month[k] == dvdd_pkg::MONTH_FEB && leap)
                   ? dvdd_pkg::LEN_W'(dvdd_pkg::FEB_LEAP_LEN) : r1_len[k];
            n2_ok[k] = r1_ok[k] && (dvdd_pkg::LEN_W'(r1_day[k]) <= len)
                    && (r1_day[k] <= dvdd_pkg::DAY_W'(len));
            // leap years in 0..y-1 = ceil(y/4) - ceil(y/100) + ceil(y/400)
            c4   = dvdd_pkg::YEAR_W'(r1_year[k][dvdd_pkg::YEAR_W-1:2])
                 + dvdd_pkg::YEAR_W'(r1_year[k][1:0] != 2'b00);
            c100 = (dvdd_pkg::Q100_W+1)'(r1_q100[k]) + (dvdd_pkg::Q100_W+1)'(rem_nz);
            c400 = (dvdd_pkg::Q100_W-1)'(r1_q100[k][dvdd_pkg::Q100_W-1:2])
                 + (dvdd_pkg::Q100_W-1)'(rem_nz || (r1_q100[k][1:0] != 2'b00));
            n2_base[k] = dvdd_pkg::DNUM_W'(r1_year[k]) * dvdd_pkg::DNUM_W'(dvdd_pkg::DAYS_YEAR)
                       + dvdd_pkg::DNUM_W'(c4) - dvdd_pkg::DNUM_W'(c100)
                       + dvdd_pkg::DNUM_W'(c400);
            n2_off[k]  = dvdd_pkg::days_before(r1_month[k])
                       + dvdd_pkg::DOFF_W'(r1_day[k])
                       + dvdd_pkg::DOFF_W'(leap && (r1_month[k] > dvdd_pkg::MONTH_FEB));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int k = 0; k < dvdd_pkg::NUM_DATE; k++) begin
                r2_base[k] <= n2_base[k];
                r2_off[k]  <= n2_off[k];
                r2_ok[k]   <= n2_ok[k];
            end
        end
    end

    // stage 3: day number
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int k = 0; k < dvdd_pkg::NUM_DATE; k++) begin
                r3_dnum[k] <= r2_base[k] + dvdd_pkg::DNUM_W'(r2_off[k]);
                r3_ok[k]   <= r2_ok[k];
            end
        end
    end

    // stage 4: absolute difference
    always_comb begin
        logic [dvdd_pkg::DNUM_W-1:0] diff;
        diff = (r3_dnum[0] >= r3_dnum[1]) ? (r3_dnum[0] - r3_dnum[1])
                                          : (r3_dnum[1] - r3_dnum[0]);
        n4_rsp.valid_a  = r3_ok[0];
        n4_rsp.valid_b  = r3_ok[1];
        n4_rsp.distance = (r3_ok[0] && r3_ok[1]) ? diff[dvdd_pkg::DIST_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_rsp <= n4_rsp;
        end
    end

`ifndef SYNTH
    a_dist_zero_if_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !(o_rsp.data.valid_a && o_rsp.data.valid_b)
        |-> o_rsp.data.distance == '0)
        else $error("distance nonzero with an invalid date");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (&r_v) && !o_rsp.ready)
        else $error("input stalled with room in the pipeline");

    a_reset_empties: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> r_v == '0)
        else $error("pipeline not empty after reset");

    a_beat_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] && en[3] |=> r_v[3])
        else $error("beat lost between stages 3 and 4");
`endif

endmodule

/* bench/tb_date_validate_and_day_distance_top.sv */
`timescale 1ns / 1ps

module tb_date_validate_and_day_distance_top;

    typedef enum int unsigned {
        DATE_WELL_FORMED,
        DATE_BROKEN,
        DATE_RAW
    } t_date_kind;

    localparam int unsigned YEAR_LO = dvdd_pkg::MIN_YEAR_DEFAULT;
    localparam int unsigned YEAR_HI = dvdd_pkg::MAX_YEAR_DEFAULT;
    localparam int unsigned RESULT_LATENCY = dvdd_pkg::NUM_STG + 6;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dvdd_req_if req_ch ();
    dvdd_rsp_if rsp_ch ();

    date_validate_and_day_distance_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    dvdd_pkg::t_rsp expected_gaps[$];
    int   mismatch_count = 0;
    bit   gap_on = 1'b1;
    bit   stall_on = 1'b1;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor
    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_is_valid(input int unsigned y, input int unsigned m,
                                         input int unsigned d);
        if (y < YEAR_LO || y > YEAR_HI)
            return 1'b0;
        if (m < 1 || m > 12)
            return 1'b0;
        return (d >= 1) && (d <= month_days(m, y));
    endfunction

    // day number counting 1 Jan of year 0 as day 1
    function automatic int unsigned day_serial(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
        int unsigned n;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d;
        for (int unsigned k = 1; k < m; k++)
            n += month_days(k, y);
        return n;
    endfunction

    function automatic dvdd_pkg::t_rsp predict_day_gap(input dvdd_pkg::t_req r);
        dvdd_pkg::t_rsp p;
        int unsigned    sa;
        int unsigned    sb;
        p.valid_a  = date_is_valid(r.year_a, r.month_a, r.day_a);
        p.valid_b  = date_is_valid(r.year_b, r.month_b, r.day_b);
        p.distance = '0;
        if (p.valid_a && p.valid_b) begin
            sa = day_serial(r.year_a, r.month_a, r.day_a);
            sb = day_serial(r.year_b, r.month_b, r.day_b);
            p.distance = (sa > sb) ? dvdd_pkg::DIST_W'(sa - sb) : dvdd_pkg::DIST_W'(sb - sa);
        end
        return p;
    endfunction

    // ---------------------------------------------------------------- result check
    always @(posedge i_clk) begin : check_day_gap
        dvdd_pkg::t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_gaps.size() == 0) begin
                $error("result beat with nothing expected: valid_a %0d valid_b %0d distance %0d",
                       rsp_ch.data.valid_a, rsp_ch.data.valid_b, rsp_ch.data.distance);
                mismatch_count++;
            end else begin
                want = expected_gaps.pop_front();
                if (rsp_ch.data.valid_a !== want.valid_a) begin
                    $error("valid_a expected %0d actual %0d", want.valid_a, rsp_ch.data.valid_a);
                    mismatch_count++;
                end
                if (rsp_ch.data.valid_b !== want.valid_b) begin
                    $error("valid_b expected %0d actual %0d", want.valid_b, rsp_ch.data.valid_b);
                    mismatch_count++;
                end
                if (rsp_ch.data.distance !== want.distance) begin
                    $error("distance expected %0d actual %0d", want.distance,
                           rsp_ch.data.distance);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result side
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= !stall_on || ($urandom_range(99) >= 28);
        end
    end

    // ---------------------------------------------------------------- request side
    task automatic send_dates(input dvdd_pkg::t_req r);
        if (gap_on) begin
            while ($urandom_range(99) < 28) begin
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_gaps.push_back(predict_day_gap(r));
    endtask

    task automatic send_fields(input int unsigned ya, input int unsigned ma, input int unsigned da,
                               input int unsigned yb, input int unsigned mb,
                               input int unsigned db);
        dvdd_pkg::t_req r;
        r.year_a  = dvdd_pkg::YEAR_W'(ya);
        r.month_a = dvdd_pkg::MONTH_W'(ma);
        r.day_a   = dvdd_pkg::DAY_W'(da);
        r.year_b  = dvdd_pkg::YEAR_W'(yb);
        r.month_b = dvdd_pkg::MONTH_W'(mb);
        r.day_b   = dvdd_pkg::DAY_W'(db);
        send_dates(r);
    endtask

    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_gaps.size() != 0);
    endtask

    function automatic void pick_date(input t_date_kind kind,
                                      output logic [dvdd_pkg::YEAR_W-1:0] y,
                                      output logic [dvdd_pkg::MONTH_W-1:0] m,
                                      output logic [dvdd_pkg::DAY_W-1:0] d);
        int unsigned yy;
        int unsigned mm;
        int unsigned len;
        int unsigned sel;
        if (kind == DATE_RAW) begin
            y = dvdd_pkg::YEAR_W'($urandom);
            m = dvdd_pkg::MONTH_W'($urandom);
            d = dvdd_pkg::DAY_W'($urandom);
            return;
        end
        sel = $urandom_range(99);
        if (sel < 10)
            yy = ($urandom_range(2) == 0) ? YEAR_LO : ($urandom_range(1) ? YEAR_HI : 2000);
        else if (sel < 30)
            yy = 4 * $urandom_range(YEAR_HI / 4, (YEAR_LO + 3) / 4);
        else
            yy = $urandom_range(YEAR_HI, YEAR_LO);
        mm  = $urandom_range(12, 1);
        len = month_days(mm, yy);
        y = dvdd_pkg::YEAR_W'(yy);
        m = dvdd_pkg::MONTH_W'(mm);
        d = ($urandom_range(99) < 20) ? dvdd_pkg::DAY_W'(len)
                                      : dvdd_pkg::DAY_W'($urandom_range(len, 1));
        if (kind == DATE_BROKEN) begin
            case ($urandom_range(2))
                0: y = $urandom_range(1) ? dvdd_pkg::YEAR_W'($urandom_range(YEAR_LO - 1, 0))
                                         : dvdd_pkg::YEAR_W'($urandom_range(16383, YEAR_HI + 1));
                1: m = ($urandom_range(3) == 0) ? dvdd_pkg::MONTH_W'(0)
                                                : dvdd_pkg::MONTH_W'($urandom_range(15, 13));
                default: d = $urandom_range(1) ? dvdd_pkg::DAY_W'(0)
                                               : dvdd_pkg::DAY_W'($urandom_range(63, len + 1));
            endcase
        end
    endfunction

    task automatic send_random_pair();
        dvdd_pkg::t_req r;
        t_date_kind     ka;
        t_date_kind     kb;
        int unsigned    sel;
        sel = $urandom_range(99);
        ka = DATE_WELL_FORMED;
        kb = DATE_WELL_FORMED;
        if (sel >= 85) begin
            ka = DATE_RAW;
            kb = $urandom_range(1) ? DATE_RAW : DATE_WELL_FORMED;
        end else if (sel >= 70) begin
            if ($urandom_range(1))
                ka = DATE_BROKEN;
            else
                kb = DATE_BROKEN;
        end
        pick_date(ka, r.year_a, r.month_a, r.day_a);
        pick_date(kb, r.year_b, r.month_b, r.day_b);
        if ($urandom_range(1) && ka == DATE_RAW) begin
            {r.year_a, r.month_a, r.day_a, r.year_b, r.month_b, r.day_b} =
                {r.year_b, r.month_b, r.day_b, r.year_a, r.month_a, r.day_a};
        end
        send_dates(r);
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_field_extremes();
        send_fields(1900, 1, 1, 1900, 1, 1);
        send_fields(1900, 1, 1, 9999, 12, 31);
        send_fields(9999, 12, 31, 1900, 1, 1);
        send_fields(2000, 2, 29, 1900, 2, 28);
        send_fields(1900, 2, 29, 2000, 3, 1);
        send_fields(2024, 2, 29, 2100, 2, 29);
        send_fields(2023, 2, 29, 2024, 2, 28);
        send_fields(1899, 12, 31, 1900, 1, 1);
        send_fields(10000, 1, 1, 9999, 1, 1);
        send_fields(16383, 15, 63, 0, 0, 0);
        send_fields(2020, 0, 10, 2020, 13, 10);
        send_fields(2020, 15, 1, 2020, 12, 0);
        send_fields(2021, 4, 31, 2021, 4, 30);
        send_fields(2021, 1, 32, 2021, 12, 31);
        send_fields(2400, 2, 29, 2300, 2, 29);
        send_fields(2020, 3, 1, 2020, 2, 29);
        send_fields(1904, 12, 31, 1905, 1, 1);
        send_fields(9999, 2, 28, 9996, 2, 29);
        send_fields(2021, 6, 31, 2021, 9, 30);
        send_fields(2021, 11, 30, 2021, 11, 31);
        send_fields(8191, 7, 32, 4096, 8, 16);
        send_fields(2047, 10, 31, 1984, 5, 31);
    endtask

    task automatic test_random_mix(input int n);
        gap_on   = 1'b1;
        stall_on = 1'b1;
        repeat (n) send_random_pair();
    endtask

    task automatic test_back_to_back(input int n);
        gap_on   = 1'b0;
        stall_on = 1'b0;
        repeat (n) send_random_pair();
        gap_on   = 1'b1;
        stall_on = 1'b1;
    endtask

    task automatic test_drain_pause(input int n);
        repeat (n) send_random_pair();
        wait_results_drained();
        repeat (n) send_random_pair();
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_random_mix(700);
        test_back_to_back(400);
        test_drain_pause(250);

        wait_results_drained();
        repeat (RESULT_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("date_validate_and_day_distance_top verification clean");
        end else begin
            $display("date_validate_and_day_distance_top verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("date_validate_and_day_distance_top verification failed");
        $finish;
    end

endmodule
